@@ rtl/lz4d_pkg.sv @@
`timescale 1ns / 1ps
// shared constants, codes and transaction types of the lz4 block decoder
package lz4d_pkg;

	localparam int HISTORY_DEPTH = 65536;
	localparam int LENGTH_WIDTH  = 32;
	localparam int MIN_MATCH_LEN = 4;

	localparam int HIST_AW   = $clog2(HISTORY_DEPTH);
	localparam int OFFSET_W  = 16;
	localparam int NIBBLE_W  = 4;

	localparam logic [NIBBLE_W-1:0] NIBBLE_EXT = 4'hf;
	localparam logic [7:0]          BYTE_EXT   = 8'hff;

	typedef enum logic [2:0] {
		ERR_NONE     = 3'd0,
		ERR_OFFSET   = 3'd1,
		ERR_BUSY     = 3'd2,
		ERR_OVERFLOW = 3'd3,
		ERR_TRUNC    = 3'd4
	} err_t;

	// per-transaction request from the parser to the history stage
	typedef struct packed {
		logic               wr;
		logic               from_mem;
		logic [HIST_AW-1:0] rd_addr;
		logic [HIST_AW-1:0] wr_addr;
		logic [7:0]         lit;
		logic               copy_pending;
		logic               done;
		err_t               err;
	} step_t;

	// one decoded result
	typedef struct packed {
		logic       out_valid;
		logic [7:0] out_byte;
		logic       copy_pending;
		logic       block_done;
		err_t       error;
	} res_t;

endpackage

@@ rtl/lz4d_stream_if.sv @@
`timescale 1ns / 1ps
// compressed input channel: byte or tick transactions
interface lz4d_stream_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, kind, data_byte, last_byte, input ready);
	modport sink   (input valid, kind, data_byte, last_byte, output ready);
endinterface

@@ rtl/lz4d_result_if.sv @@
`timescale 1ns / 1ps
// decoded result channel
interface lz4d_result_if;
	logic       valid;
	logic       ready;
	logic       out_valid;
	logic [7:0] out_byte;
	logic       copy_pending;
	logic       block_done;
	logic [2:0] error;

	modport source (output valid, out_valid, out_byte, copy_pending, block_done, error,
		input ready);
	modport sink   (input valid, out_valid, out_byte, copy_pending, block_done, error,
		output ready);
endinterface

@@ rtl/lz4d_block_decoder_top.sv @@
`timescale 1ns / 1ps
// top level of the lz4 block decoder: handshakes, pipeline control and output register

// Decodes an lz4 block fed one compressed byte per transaction and returns exactly
// one result transaction for every input transaction. Literal bytes come back with
// the byte that carried them; match bytes are produced one per tick transaction
// (kind = 1) while copy_pending is high, copied byte by byte from a 64 KiB history
// ring so that overlapping matches repeat correctly. History survives across blocks
// and needs no clearing after reset. Throughput is one transaction per clock while
// the result side keeps taking results: every transaction makes at most one read and
// one write of the simple dual-port history memory, and a write to the entry read by
// the next tick is forwarded. A result passes the stage-one registers (parser state
// and memory read, loaded at the accepting edge) and then the output register, which
// loads when stage one moves on and so waits while the output stalls. Errors (bad
// offset, byte during copy, length overflow, truncated block) are reported on the result;
// a byte during a copy is dropped and the copy goes on, other errors abandon the sequence.
module lz4_block_decoder_top import lz4d_pkg::*; (
	input logic          clk,
	input logic          arst_n,
	lz4d_stream_if.sink  stream,
	lz4d_result_if.source result
);

	step_t step;
	res_t  res_s1;
	res_t  res_s2;

	logic  s1_valid_q;
	logic  s2_valid_q;
	logic  s1_adv;
	logic  s1_move;
	logic  accept;

	// stage one drains when the output register is empty or being taken
	assign s1_adv        = !s2_valid_q || result.ready;
	assign s1_move       = s1_valid_q && s1_adv;
	assign stream.ready  = !s1_valid_q || s1_adv;
	assign accept        = stream.valid && stream.ready;

	lz4d_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.kind      (stream.kind),
		.data_byte (stream.data_byte),
		.last_byte (stream.last_byte),
		.step      (step)
	);

	lz4d_history u_history (
		.clk     (clk),
		.accept  (accept),
		.step    (step),
		.s1_move (s1_move),
		.res     (res_s1)
	);

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
		end else begin
			if (accept)
				s1_valid_q <= 1'b1;
			else if (s1_move)
				s1_valid_q <= 1'b0;
			if (s1_move)
				s2_valid_q <= 1'b1;
			else if (result.ready)
				s2_valid_q <= 1'b0;
		end
	end

	// output register, payload only
	always_ff @(posedge clk) begin
		if (s1_move)
			res_s2 <= res_s1;
	end

	assign result.valid        = s2_valid_q;
	assign result.out_valid    = res_s2.out_valid;
	assign result.out_byte     = res_s2.out_byte;
	assign result.copy_pending = res_s2.copy_pending;
	assign result.block_done   = res_s2.block_done;
	assign result.error        = res_s2.error;

	// a clean block end never carries an error and leaves no copy behind
	a_done_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.block_done) |-> (result.error == ERR_NONE && !result.copy_pending))
		else $error("block_done with error or pending copy");

	// a byte refused during a copy leaves the copy running
	a_busy_keeps_copy: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.error == ERR_BUSY) |-> (result.copy_pending && !result.out_valid))
		else $error("busy error without a pending copy");

	// no decoded byte means the byte field reads zero
	a_idle_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.out_valid) |-> (result.out_byte == 8'd0))
		else $error("nonzero byte on a result without data");

endmodule

@@ rtl/lz4d_parser.sv @@
`timescale 1ns / 1ps
// sequence parser: token, lengths, offset, copy counters and history pointers
module lz4d_parser import lz4d_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic       kind,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output step_t      step
);

	typedef enum logic [2:0] {
		PH_TOKEN,
		PH_LITEXT,
		PH_LIT,
		PH_OFFLO,
		PH_OFFHI,
		PH_MATCHEXT,
		PH_COPY,
		PH_COPYLAST
	} phase_t;

	localparam int SW = OFFSET_W + 1;

	phase_t                  phase_q, phase_d;
	logic [LENGTH_WIDTH-1:0] lit_rem_q, lit_rem_d;
	logic [LENGTH_WIDTH-1:0] match_rem_q, match_rem_d;
	logic [NIBBLE_W-1:0]     nibble_q, nibble_d;
	logic [OFFSET_W-1:0]     offset_q, offset_d;
	logic [HIST_AW-1:0]      wp_q, wp_d;
	logic [HIST_AW:0]        produced_q, produced_d;

	logic                    copying;
	logic                    put;
	logic                    drop;
	logic [SW-1:0]           wp_ext, off_ext, src_ext;
	logic [OFFSET_W-1:0]     new_off;
	logic [LENGTH_WIDTH:0]   sum;
	logic [LENGTH_WIDTH-1:0] lit_dec;
	logic [NIBBLE_W-1:0]     lit_nib;

	assign copying = (phase_q == PH_COPY) || (phase_q == PH_COPYLAST);

	// source of the next match byte, wrapping around the ring
	assign wp_ext  = SW'(wp_q);
	assign off_ext = SW'(offset_q);
	always_comb begin
		if (off_ext > wp_ext)
			src_ext = wp_ext + SW'(HISTORY_DEPTH) - off_ext;
		else
			src_ext = wp_ext - off_ext;
	end

	always_comb begin
		phase_d     = phase_q;
		lit_rem_d   = lit_rem_q;
		match_rem_d = match_rem_q;
		nibble_d    = nibble_q;
		offset_d    = offset_q;
		wp_d        = wp_q;
		produced_d  = produced_q;
		put         = 1'b0;
		drop        = 1'b0;
		step        = '0;
		step.err    = ERR_NONE;
		new_off     = {data_byte, offset_q[7:0]};
		sum         = '0;
		lit_dec     = (lit_rem_q != '0) ? lit_rem_q - 1'b1 : lit_rem_q;
		lit_nib     = data_byte[7:4];

		if (kind) begin
			if (copying && (match_rem_q != '0)) begin
				put           = 1'b1;
				step.from_mem = 1'b1;
				match_rem_d   = match_rem_q - 1'b1;
				if (match_rem_d == '0) begin
					step.done = (phase_q == PH_COPYLAST);
					drop      = 1'b1;
				end
			end
		end else begin
			case (phase_q)
				PH_TOKEN: begin
					nibble_d  = data_byte[3:0];
					lit_rem_d = LENGTH_WIDTH'(lit_nib);
					if (lit_nib == NIBBLE_EXT)
						phase_d = PH_LITEXT;
					else if (lit_nib != '0)
						phase_d = PH_LIT;
					else
						phase_d = PH_OFFLO;
					if (last_byte) begin
						if (lit_nib == '0)
							step.done = 1'b1;
						else
							step.err = ERR_TRUNC;
						drop = 1'b1;
					end
				end
				PH_LITEXT: begin
					sum = {1'b0, lit_rem_q} + (LENGTH_WIDTH + 1)'(data_byte);
					if (sum[LENGTH_WIDTH]) begin
						step.err = ERR_OVERFLOW;
						drop     = 1'b1;
					end else begin
						lit_rem_d = sum[LENGTH_WIDTH-1:0];
						if (data_byte != BYTE_EXT)
							phase_d = PH_LIT;
						if (last_byte) begin
							step.err = ERR_TRUNC;
							drop     = 1'b1;
						end
					end
				end
				PH_LIT: begin
					put       = 1'b1;
					lit_rem_d = lit_dec;
					if (lit_dec == '0)
						phase_d = PH_OFFLO;
					if (last_byte) begin
						if (lit_dec == '0)
							step.done = 1'b1;
						else
							step.err = ERR_TRUNC;
						drop = 1'b1;
					end
				end
				PH_OFFLO: begin
					offset_d = OFFSET_W'(data_byte);
					phase_d  = PH_OFFHI;
					if (last_byte) begin
						step.err = ERR_TRUNC;
						drop     = 1'b1;
					end
				end
				PH_OFFHI: begin
					if ((new_off == '0) || (SW'(new_off) > SW'(produced_q))) begin
						step.err = ERR_OFFSET;
						drop     = 1'b1;
					end else begin
						offset_d = new_off;
						if (nibble_q == NIBBLE_EXT) begin
							match_rem_d = LENGTH_WIDTH'(NIBBLE_EXT);
							phase_d     = PH_MATCHEXT;
							if (last_byte) begin
								step.err = ERR_TRUNC;
								drop     = 1'b1;
							end
						end else begin
							match_rem_d = LENGTH_WIDTH'(nibble_q) + LENGTH_WIDTH'(MIN_MATCH_LEN);
							phase_d     = last_byte ? PH_COPYLAST : PH_COPY;
						end
					end
				end
				PH_MATCHEXT: begin
					sum = {1'b0, match_rem_q} + (LENGTH_WIDTH + 1)'(data_byte);
					if (data_byte != BYTE_EXT)
						sum = sum + (LENGTH_WIDTH + 1)'(MIN_MATCH_LEN);
					if (sum[LENGTH_WIDTH]) begin
						step.err = ERR_OVERFLOW;
						drop     = 1'b1;
					end else begin
						match_rem_d = sum[LENGTH_WIDTH-1:0];
						if (data_byte != BYTE_EXT)
							phase_d = last_byte ? PH_COPYLAST : PH_COPY;
						else if (last_byte) begin
							step.err = ERR_TRUNC;
							drop     = 1'b1;
						end
					end
				end
				default: begin
					// byte while a copy is running: dropped, state kept
					step.err = ERR_BUSY;
				end
			endcase
		end

		if (drop) begin
			phase_d     = PH_TOKEN;
			lit_rem_d   = '0;
			match_rem_d = '0;
			nibble_d    = '0;
			offset_d    = '0;
		end

		if (put) begin
			wp_d = (wp_q == HIST_AW'(HISTORY_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (produced_q != (HIST_AW + 1)'(HISTORY_DEPTH))
				produced_d = produced_q + 1'b1;
		end

		step.wr           = put;
		step.wr_addr      = wp_q;
		step.rd_addr      = src_ext[HIST_AW-1:0];
		step.lit          = data_byte;
		step.copy_pending = (phase_d == PH_COPY) || (phase_d == PH_COPYLAST);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_TOKEN;
			lit_rem_q   <= '0;
			match_rem_q <= '0;
			nibble_q    <= '0;
			offset_q    <= '0;
			wp_q        <= '0;
			produced_q  <= '0;
		end else if (accept) begin
			phase_q     <= phase_d;
			lit_rem_q   <= lit_rem_d;
			match_rem_q <= match_rem_d;
			nibble_q    <= nibble_d;
			offset_q    <= offset_d;
			wp_q        <= wp_d;
			produced_q  <= produced_d;
		end
	end

endmodule

@@ rtl/lz4d_history.sv @@
`timescale 1ns / 1ps
// history ring memory with read stage, write-back and same-entry forwarding
module lz4d_history import lz4d_pkg::*; (
	input  logic  clk,
	input  logic  accept,
	input  step_t step,
	input  logic  s1_move,
	output res_t  res
);

	logic [7:0] mem [HISTORY_DEPTH];

	step_t      st_s1;
	logic [7:0] rd_q;
	logic       fwd_s1;
	logic [7:0] fwd_data_s1;
	logic [7:0] byte_s1;

	// byte of the transaction in stage one: literal, forwarded or read from the ring
	always_comb begin
		if (!st_s1.wr)
			byte_s1 = '0;
		else if (!st_s1.from_mem)
			byte_s1 = st_s1.lit;
		else if (fwd_s1)
			byte_s1 = fwd_data_s1;
		else
			byte_s1 = rd_q;
	end

	always_ff @(posedge clk) begin
		if (s1_move && st_s1.wr)
			mem[st_s1.wr_addr] <= byte_s1;
		if (accept) begin
			st_s1       <= step;
			rd_q        <= mem[step.rd_addr];
			// the entry written this cycle is read back with its old content
			fwd_s1      <= s1_move && st_s1.wr && (st_s1.wr_addr == step.rd_addr);
			fwd_data_s1 <= byte_s1;
		end
	end

	always_comb begin
		res.out_valid    = st_s1.wr;
		res.out_byte     = byte_s1;
		res.copy_pending = st_s1.copy_pending;
		res.block_done   = st_s1.done;
		res.error        = st_s1.err;
	end

endmodule
